// ===== rtl/izna_pkg.sv =====
// izna_pkg: shared types, constants and helpers of the izhikevich neuron array engine
// used by izna_ctrl, izna_dp and izhikevich_neuron_array_engine_unit
// no dependencies
package izna_pkg;

    // default sizes and arithmetic constants
    localparam int NEURONS_DEF = 1024;
    localparam int WINDOW_DEF  = 32;
    localparam int FRAC_DEF    = 16;
    localparam int RATE_BITS   = 16;

    // port widths
    localparam int CMD_W       = 2;
    localparam int NEURON_W    = 10;
    localparam int DELAY_W     = 5;
    localparam int WEIGHT_W    = 24;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // register reset values
    localparam logic [10:0]        EXC_COUNT_RST = 11'd800;
    localparam logic [15:0]        RATE_EXC_RST  = 16'd1311;
    localparam logic [15:0]        RATE_INH_RST  = 16'd6554;
    localparam logic [15:0]        SENS_RST      = 16'd13107;
    localparam logic signed [23:0] RESET_POT_RST = -24'sd4259840;
    localparam logic [21:0]        JUMP_EXC_RST  = 22'd524288;
    localparam logic [21:0]        JUMP_INH_RST  = 22'd131072;
    localparam logic [22:0]        THR_RST       = 23'd1966080;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXC_COUNT,
        CFG_RATE_EXC,
        CFG_RATE_INH,
        CFG_SENS,
        CFG_RESET_POT,
        CFG_JUMP_EXC,
        CFG_JUMP_INH,
        CFG_THRESHOLD
    } t_cfg_idx;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPIKE,
        CMD_ADD,
        CMD_INTEG,
        CMD_ADV
    } t_cmd;

    typedef struct packed {
        logic [10:0]        exc_count;
        logic [15:0]        rate_exc;
        logic [15:0]        rate_inh;
        logic [15:0]        sens;
        logic signed [23:0] reset_pot;
        logic [21:0]        jump_exc;
        logic [21:0]        jump_inh;
        logic [22:0]        thr;
    } t_cfg;

    // datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_READ,
        OP_LOAD,
        OP_SPIKE,
        OP_ADD,
        OP_ADV,
        OP_SQ,
        OP_QLO,
        OP_QHI,
        OP_QSUM,
        OP_SUM,
        OP_VUPD,
        OP_BV,
        OP_DLO,
        OP_DHI,
        OP_DSUM,
        OP_UUPD,
        OP_WB
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SPIKE,
        ST_ADD,
        ST_ADV,
        ST_SQ,
        ST_QLO,
        ST_QHI,
        ST_QSUM,
        ST_SUM,
        ST_VUPD,
        ST_BV,
        ST_DLO,
        ST_DHI,
        ST_DSUM,
        ST_UUPD,
        ST_WB,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic nvalid;
        t_cmd cmd;
    } t_dp_sts;

    typedef struct packed {
        logic               fired;
        logic signed [31:0] membrane;
        logic signed [31:0] recovery;
    } t_res;

    // clip to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX) begin
            r = 32'sh7fffffff;
        end else if (x < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/izhikevich_neuron_array_engine_unit.sv =====
// izhikevich_neuron_array_engine_unit: top level, configuration registers and output register
// depends on izna_pkg, izna_ctrl, izna_dp
//
// Usage: commands enter on the s_axis channel, one word each: tuser carries the
// command (spike check, add current, integrate, advance time), tdata the neuron
// index, slot delay and weight. Every accepted word gives exactly one result word
// on m_axis: fired flag, membrane and recovery of the addressed neuron after the
// command (zeros for an index beyond the array).
// Timing: one word at a time through a shared 33x33 multiplier. Spike check, add
// current and advance time pass through accept, read, load, their one operation and
// done; integrate runs two membrane half steps (square, quad low, quad high, quad
// sum, sum, membrane update) and the recovery step (b times v, low and high product
// halves, sum, recovery update, write back), all on that one multiplier.
// The result sits in an output register; the engine takes the next word while it
// waits, and if the receiver stalls it holds the next result, accepting nothing,
// until that register frees up.
// Reset: the configuration registers take their defaults at once; then a clearing
// pass writes the state and current memories while s_axis is not ready.
// Configuration writes belong between words, with nothing in flight.
module izhikevich_neuron_array_engine_unit
    import izna_pkg::*;
#(
    parameter int NEURONS   = NEURONS_DEF,
    parameter int WINDOW    = WINDOW_DEF,
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // neuron [9:0], delay [14:10], weight [38:15], zero [39]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // command [1:0]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // fired [0], membrane [32:1], recovery [64:33], zero [71:65]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_res    w_res;
    logic    r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic    w_out_free, w_out_load;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exc_count <= EXC_COUNT_RST;
            r_cfg.rate_exc  <= RATE_EXC_RST;
            r_cfg.rate_inh  <= RATE_INH_RST;
            r_cfg.sens      <= SENS_RST;
            r_cfg.reset_pot <= RESET_POT_RST;
            r_cfg.jump_exc  <= JUMP_EXC_RST;
            r_cfg.jump_inh  <= JUMP_INH_RST;
            r_cfg.thr       <= THR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_EXC_COUNT: r_cfg.exc_count <= i_cfg_data[10:0];
                CFG_RATE_EXC:  r_cfg.rate_exc  <= i_cfg_data[15:0];
                CFG_RATE_INH:  r_cfg.rate_inh  <= i_cfg_data[15:0];
                CFG_SENS:      r_cfg.sens      <= i_cfg_data[15:0];
                CFG_RESET_POT: r_cfg.reset_pot <= $signed(i_cfg_data[23:0]);
                CFG_JUMP_EXC:  r_cfg.jump_exc  <= i_cfg_data[21:0];
                CFG_JUMP_INH:  r_cfg.jump_inh  <= i_cfg_data[21:0];
                CFG_THRESHOLD: r_cfg.thr       <= i_cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

    izna_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (w_out_free),
        .o_out_load (w_out_load),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    izna_dp #(
        .NEURONS   (NEURONS),
        .WINDOW    (WINDOW),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_command (t_cmd'(i_s_axis_tuser)),
        .i_neuron  (i_s_axis_tdata[9:0]),
        .i_delay   (i_s_axis_tdata[14:10]),
        .i_weight  ($signed(i_s_axis_tdata[38:15])),
        .i_cfg     (r_cfg),
        .o_sts     (w_sts),
        .o_res     (w_res)
    );

    // output register
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {7'd0, w_res.recovery, w_res.membrane, w_res.fired};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/izna_ctrl.sv =====
// izna_ctrl: sequencer of the neuron engine, issues one datapath operation a cycle
// depends on izna_pkg
module izna_ctrl
    import izna_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_free,
    output logic    o_out_load,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_half, n_half;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_half  <= n_half;
        end
    end

    // next state and operation
    always_comb begin
        n_state    = r_state;
        n_half     = r_half;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.op = OP_READ;
                n_state  = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_half   = 1'b0;
                if (i_sts.cmd == CMD_ADV) begin
                    n_state = ST_ADV;
                end else if (!i_sts.nvalid) begin
                    n_state = ST_DONE;
                end else if (i_sts.cmd == CMD_SPIKE) begin
                    n_state = ST_SPIKE;
                end else if (i_sts.cmd == CMD_ADD) begin
                    n_state = ST_ADD;
                end else begin
                    n_state = ST_SQ;
                end
            end
            ST_SPIKE: begin
                o_cmd.op = OP_SPIKE;
                n_state  = ST_DONE;
            end
            ST_ADD: begin
                o_cmd.op = OP_ADD;
                n_state  = ST_DONE;
            end
            ST_ADV: begin
                o_cmd.op = OP_ADV;
                n_state  = ST_DONE;
            end
            // membrane half step
            ST_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = ST_QLO;
            end
            ST_QLO: begin
                o_cmd.op = OP_QLO;
                n_state  = ST_QHI;
            end
            ST_QHI: begin
                o_cmd.op = OP_QHI;
                n_state  = ST_QSUM;
            end
            ST_QSUM: begin
                o_cmd.op = OP_QSUM;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = OP_SUM;
                n_state  = ST_VUPD;
            end
            ST_VUPD: begin
                o_cmd.op = OP_VUPD;
                if (!r_half) begin
                    n_half  = 1'b1;
                    n_state = ST_SQ;
                end else begin
                    n_state = ST_BV;
                end
            end
            // recovery step
            ST_BV: begin
                o_cmd.op = OP_BV;
                n_state  = ST_DLO;
            end
            ST_DLO: begin
                o_cmd.op = OP_DLO;
                n_state  = ST_DHI;
            end
            ST_DHI: begin
                o_cmd.op = OP_DHI;
                n_state  = ST_DSUM;
            end
            ST_DSUM: begin
                o_cmd.op = OP_DSUM;
                n_state  = ST_UUPD;
            end
            ST_UUPD: begin
                o_cmd.op = OP_UUPD;
                n_state  = ST_WB;
            end
            ST_WB: begin
                o_cmd.op = OP_WB;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/izna_dp.sv =====
// izna_dp: neuron state memories, current ring, shared multiplier and arithmetic
// depends on izna_pkg; driven one operation a cycle by izna_ctrl
module izna_dp
    import izna_pkg::*;
#(
    parameter int NEURONS   = NEURONS_DEF,
    parameter int WINDOW    = WINDOW_DEF,
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  t_cmd                       i_command,
    input  logic [NEURON_W-1:0]        i_neuron,
    input  logic [DELAY_W-1:0]         i_delay,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    input  t_cfg                       i_cfg,
    output t_dp_sts                    o_sts,
    output t_res                       o_res
);

    localparam int NB = $clog2(NEURONS);
    localparam int SB = $clog2(WINDOW);
    localparam int RB = SB + NB;
    localparam logic signed [63:0] KQ   = ((64'sd4 <<< FRAC_BITS) + 64'sd50) / 64'sd100;
    localparam logic signed [63:0] C140 = 64'sd140 <<< FRAC_BITS;
    localparam logic signed [31:0] V_RST = -32'sd65 <<< FRAC_BITS;
    localparam logic signed [31:0] U_RST = -32'sd13 <<< FRAC_BITS;

    // delay modulo window, small constant table
    function automatic logic [SB-1:0] f_dmod(input logic [DELAY_W-1:0] d);
        logic [SB-1:0] r;
        r = '0;
        for (int i = 0; i < 32; i++) begin
            if (d == DELAY_W'(i)) begin
                r = SB'(i % WINDOW);
            end
        end
        return r;
    endfunction

    logic signed [31:0] mem_v [1 << NB];
    logic signed [31:0] mem_u [1 << NB];
    logic signed [31:0] mem_c [1 << RB];

    logic [SB-1:0]      r_slot;
    logic [RB-1:0]      r_clr;
    t_cmd               r_cmd;
    logic               r_nvalid;
    logic               r_exc;
    logic [NB-1:0]      r_idx;
    logic [RB-1:0]      r_raddr;
    logic signed [23:0] r_w;
    logic signed [31:0] r_rd_v, r_rd_u, r_rd_c;
    logic signed [31:0] r_v, r_u, r_cur;
    logic               r_fired;
    logic signed [63:0] r_prod, r_acc, r_lin;
    logic signed [32:0] r_hi;

    logic [31:0]        w_nz;
    logic               w_in_valid;
    logic [NB-1:0]      w_in_idx;
    logic [SB:0]        w_tsum;
    logic [SB-1:0]      w_ts;
    logic [SB-1:0]      w_slot_nx;
    logic signed [63:0] w_v64, w_u64, w_c64, w_w64;
    logic signed [63:0] w_sq, w_d;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod_full;
    logic [15:0]        w_rate;
    logic               w_fire;
    logic signed [31:0] w_rst_v, w_jump_u;
    logic               w_vu_we;
    logic signed [31:0] w_v_wd, w_u_wd;

    // input decode
    assign w_nz       = {22'd0, i_neuron};
    assign w_in_valid = w_nz < 32'(NEURONS);
    assign w_in_idx   = w_nz[NB-1:0];
    assign w_tsum     = {1'b0, r_slot} + {1'b0, f_dmod(i_delay)};
    assign w_ts       = (w_tsum >= (SB+1)'(WINDOW)) ? SB'(w_tsum - (SB+1)'(WINDOW))
                                                    : w_tsum[SB-1:0];
    assign w_slot_nx  = (r_slot == SB'(WINDOW - 1)) ? '0 : r_slot + 1'b1;

    // wide views of the working values
    assign w_v64 = r_v;
    assign w_u64 = r_u;
    assign w_c64 = r_cur;
    assign w_w64 = r_w;
    assign w_sq  = r_prod >>> FRAC_BITS;
    assign w_d   = (r_prod >>> RATE_BITS) - w_u64;
    assign w_rate = r_exc ? i_cfg.rate_exc : i_cfg.rate_inh;

    // spike check
    assign w_fire   = w_v64 > $signed({41'd0, i_cfg.thr});
    assign w_rst_v  = i_cfg.reset_pot;
    assign w_jump_u = sat32(w_u64 + $signed({42'd0, r_exc ? i_cfg.jump_exc
                                                         : i_cfg.jump_inh}));

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_SQ: begin
                w_ma = {r_v[31], r_v};
                w_mb = {r_v[31], r_v};
            end
            OP_QLO: begin
                w_ma = {1'b0, w_sq[31:0]};
                w_mb = KQ[32:0];
            end
            OP_QHI: begin
                w_ma = r_hi;
                w_mb = KQ[32:0];
            end
            OP_BV: begin
                w_ma = {r_v[31], r_v};
                w_mb = {17'd0, i_cfg.sens};
            end
            OP_DLO: begin
                w_ma = {1'b0, w_d[31:0]};
                w_mb = {17'd0, w_rate};
            end
            OP_DHI: begin
                w_ma = r_hi;
                w_mb = {17'd0, w_rate};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod_full = w_ma * w_mb;

    // slot counter and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_clr  <= '0;
        end else begin
            if (i_cmd.op == OP_ADV) begin
                r_slot <= w_slot_nx;
            end
            if (i_cmd.op == OP_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod_full[63:0];
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_cmd    <= i_command;
                r_nvalid <= w_in_valid;
                r_exc    <= {1'b0, i_neuron} < i_cfg.exc_count;
                r_idx    <= w_in_idx;
                r_raddr  <= (i_command == CMD_INTEG) ? {r_slot, w_in_idx} : {w_ts, w_in_idx};
                r_w      <= i_weight;
            end
            OP_LOAD: begin
                r_v     <= r_rd_v;
                r_u     <= r_rd_u;
                r_cur   <= r_rd_c;
                r_fired <= 1'b0;
            end
            OP_SPIKE: begin
                if (w_fire) begin
                    r_fired <= 1'b1;
                    r_v     <= w_rst_v;
                    r_u     <= w_jump_u;
                end
            end
            OP_QLO: r_hi <= {w_sq[63], w_sq[63:32]};
            OP_QHI: r_acc <= r_prod;
            OP_QSUM: begin
                r_acc <= (r_acc + (r_prod <<< 32)) >>> FRAC_BITS;
                r_lin <= (w_v64 <<< 2) + w_v64 + C140 - w_u64 + w_c64;
            end
            OP_SUM: r_acc <= r_acc + r_lin;
            OP_VUPD: r_v <= sat32(w_v64 + (r_acc >>> 1));
            OP_DLO: r_hi <= {w_d[63], w_d[63:32]};
            OP_DHI: r_acc <= r_prod;
            OP_DSUM: r_acc <= (r_acc + (r_prod <<< 32)) >>> RATE_BITS;
            OP_UUPD: r_u <= sat32(w_u64 + r_acc);
            default: begin
            end
        endcase
    end

    // neuron state write back
    assign w_vu_we = (i_cmd.op == OP_WB) || ((i_cmd.op == OP_SPIKE) && w_fire);
    assign w_v_wd  = (i_cmd.op == OP_WB) ? r_v : w_rst_v;
    assign w_u_wd  = (i_cmd.op == OP_WB) ? r_u : w_jump_u;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLEAR) begin
            mem_v[r_clr[NB-1:0]] <= V_RST;
            mem_u[r_clr[NB-1:0]] <= U_RST;
        end else if (w_vu_we) begin
            mem_v[r_idx] <= w_v_wd;
            mem_u[r_idx] <= w_u_wd;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd_v <= mem_v[r_idx];
            r_rd_u <= mem_u[r_idx];
        end
    end

    // current ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLEAR) begin
            mem_c[r_clr] <= '0;
        end else if (i_cmd.op == OP_ADD) begin
            mem_c[r_raddr] <= sat32(w_c64 + w_w64);
        end else if (i_cmd.op == OP_WB) begin
            mem_c[r_raddr] <= '0;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd_c <= mem_c[r_raddr];
        end
    end

    // status and result
    assign o_sts.clr_done = &r_clr;
    assign o_sts.nvalid   = r_nvalid;
    assign o_sts.cmd      = r_cmd;

    assign o_res.fired    = r_fired & r_nvalid;
    assign o_res.membrane = r_nvalid ? r_v : '0;
    assign o_res.recovery = r_nvalid ? r_u : '0;

endmodule

// ===== sim/tb_izhikevich_neuron_array_engine_unit.sv =====
// tb_izhikevich_neuron_array_engine_unit: self-checking bench for the neuron array engine
// predicts every result word with its own fixed-point model in a small scoreboard class
// depends on izna_pkg and izhikevich_neuron_array_engine_unit
`timescale 1ns / 100ps

module tb_izhikevich_neuron_array_engine_unit;
    import izna_pkg::*;

    localparam int  N_CELLS   = 1024;
    localparam int  N_SLOTS   = 32;
    localparam longint K_QUAD = ((64'sd4 <<< 16) + 50) / 100;

    // neuron state predictor and expected-result store
    class neuron_scoreboard;
        int     v_mem [N_CELLS];
        int     u_rec [N_CELLS];
        int     ring [N_SLOTS][N_CELLS];
        int     now_slot;
        int     exc_count, rate_exc, rate_inh, sens, reset_pot, jump_exc, jump_inh, thr;
        t_res   pending [$];
        int     errors;

        function new();
            for (int i = 0; i < N_CELLS; i++) begin
                v_mem[i] = -65 * 65536;
                u_rec[i] = -13 * 65536;
                for (int t = 0; t < N_SLOTS; t++) ring[t][i] = 0;
            end
            now_slot  = 0;
            exc_count = 800;   rate_exc = 1311;  rate_inh = 6554;  sens = 13107;
            reset_pot = -4259840; jump_exc = 524288; jump_inh = 131072; thr = 1966080;
            errors    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [23:0] val);
            case (idx)
                CFG_EXC_COUNT: exc_count = int'(val[10:0]);
                CFG_RATE_EXC:  rate_exc  = int'(val[15:0]);
                CFG_RATE_INH:  rate_inh  = int'(val[15:0]);
                CFG_SENS:      sens      = int'(val[15:0]);
                CFG_RESET_POT: reset_pot = int'($signed(val));
                CFG_JUMP_EXC:  jump_exc  = int'(val[21:0]);
                CFG_JUMP_INH:  jump_inh  = int'(val[21:0]);
                CFG_THRESHOLD: thr       = int'(val[22:0]);
                default: ;
            endcase
        endfunction

        function int clip32(longint x);
            if (x > 64'sd2147483647) return 32'sh7fffffff;
            if (x < -64'sd2147483648) return 32'sh80000000;
            return int'(x);
        endfunction

        // one membrane half step
        function int v_half(int v, int u, int cur);
            longint vv, sq, quad, s;
            vv   = v;
            sq   = (vv * vv) >>> 16;
            quad = (sq * K_QUAD) >>> 16;
            s    = quad + 5 * vv + (64'sd140 <<< 16) - longint'(u) + longint'(cur);
            return clip32(vv + (s >>> 1));
        endfunction

        // note an accepted word and predict its result
        function void note_word(t_cmd cmd, logic [9:0] n, logic [4:0] dly, logic [23:0] w);
            t_res   r;
            bit     exc;
            int     v, u, cur, ts;
            longint a, bv;
            exc = n < exc_count;
            r.fired = 1'b0;
            case (cmd)
                CMD_ADV: now_slot = (now_slot + 1) % N_SLOTS;
                CMD_SPIKE: begin
                    if (longint'(v_mem[n]) > longint'(thr)) begin
                        r.fired  = 1'b1;
                        v_mem[n] = reset_pot;
                        u_rec[n] = clip32(longint'(u_rec[n]) + (exc ? jump_exc : jump_inh));
                    end
                end
                CMD_ADD: begin
                    ts = (now_slot + dly) % N_SLOTS;
                    ring[ts][n] = clip32(longint'(ring[ts][n]) + longint'($signed(w)));
                end
                default: begin
                    v   = v_mem[n];
                    u   = u_rec[n];
                    cur = ring[now_slot][n];
                    a   = exc ? rate_exc : rate_inh;
                    v   = v_half(v, u, cur);
                    v   = v_half(v, u, cur);
                    bv  = (longint'(sens) * longint'(v)) >>> 16;
                    u   = clip32(longint'(u) + ((a * (bv - longint'(u))) >>> 16));
                    v_mem[n] = v;
                    u_rec[n] = u;
                    ring[now_slot][n] = 0;
                end
            endcase
            r.membrane = v_mem[n];
            r.recovery = u_rec[n];
            pending.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // compare a result word with the oldest expectation
        task check_word(logic [OUT_DATA_W-1:0] d);
            t_res e;
            if (pending.size() == 0) begin
                report("unexpected word", d[32:1], 0);
            end else begin
                e = pending.pop_front();
                if (d[0] !== e.fired) report("fired", d[0], e.fired);
                if ($signed(d[32:1]) !== e.membrane) report("membrane", $signed(d[32:1]), e.membrane);
                if ($signed(d[64:33]) !== e.recovery) report("recovery", $signed(d[64:33]), e.recovery);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic [CMD_W-1:0]      i_s_axis_tuser;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    neuron_scoreboard sb;
    bit               idle_on;

    izhikevich_neuron_array_engine_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #8ms;
        $display("FAIL");
        $finish;
    end

    // one register write
    task write_reg(t_cfg_idx idx, logic [23:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // write all eight registers
    task write_all(int ec, int re, int ri, int sn, int rp, int je, int ji, int th);
        write_reg(CFG_EXC_COUNT, 24'(ec));
        write_reg(CFG_RATE_EXC, 24'(re));
        write_reg(CFG_RATE_INH, 24'(ri));
        write_reg(CFG_SENS, 24'(sn));
        write_reg(CFG_RESET_POT, 24'(rp));
        write_reg(CFG_JUMP_EXC, 24'(je));
        write_reg(CFG_JUMP_INH, 24'(ji));
        write_reg(CFG_THRESHOLD, 24'(th));
    endtask

    // send one command word, with an optional idle burst first
    task send_word(t_cmd cmd, logic [9:0] n, logic [4:0] dly, logic [23:0] w);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {1'b0, w, dly, n};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_word(cmd, n, dly, w);
    endtask

    // wait until every expected word has come, then let the engine settle
    task drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function logic [9:0] pick_neuron();
        case ($urandom_range(0, 5))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd799 + 10'($urandom_range(0, 1));
            3: return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(0, 5));
        endcase
    endfunction

    // random mix, weighted toward current and integration so neurons fire
    task random_words(int count);
        int         k;
        t_cmd       cmd;
        logic [23:0] w;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            cmd = k < 35 ? CMD_ADD : k < 65 ? CMD_INTEG : k < 85 ? CMD_SPIKE : CMD_ADV;
            w = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 24'h3fffff));
            send_word(cmd, pick_neuron(), 5'($urandom), w);
        end
    endtask

    // receiver with random stall bursts
    initial begin
        int stall;
        stall = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_word(o_m_axis_tdata);
            if (stall > 0) begin
                stall--;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 19);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin
        sb = new();
        idle_on         = 1'b1;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_SPIKE;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_EXC_COUNT;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_all(800, 1311, 6554, 13107, -4259840, 524288, 131072, 1966080);

        // directed: field extremes, every command, slot wrap, a forced spike
        send_word(CMD_SPIKE, 10'd0, 5'd0, 24'd0);
        send_word(CMD_ADD, 10'd0, 5'd0, 24'h7fffff);
        send_word(CMD_ADD, 10'd0, 5'd0, 24'h7fffff);
        send_word(CMD_ADD, 10'd1023, 5'd31, 24'h800000);
        send_word(CMD_INTEG, 10'd0, 5'd0, 24'd0);
        send_word(CMD_SPIKE, 10'd0, 5'd0, 24'd0);
        send_word(CMD_INTEG, 10'd799, 5'd0, 24'd0);
        send_word(CMD_INTEG, 10'd800, 5'd0, 24'd0);
        send_word(CMD_ADD, 10'd800, 5'd1, 24'h7fffff);
        send_word(CMD_ADV, 10'd800, 5'd31, 24'hffffff);
        send_word(CMD_INTEG, 10'd800, 5'd0, 24'd0);
        send_word(CMD_SPIKE, 10'd800, 5'd0, 24'd0);
        send_word(CMD_SPIKE, 10'd1023, 5'd0, 24'd0);
        for (int i = 0; i < 31; i++) send_word(CMD_ADV, 10'd5, 5'd0, 24'd0);
        send_word(CMD_INTEG, 10'd1023, 5'd0, 24'd0);
        send_word(CMD_ADD, 10'd3, 5'd31, 24'h000001);
        drain();

        random_words(200);
        drain();

        // extremes, low side of the thresholds
        write_all(0, 65535, 0, 65535, -8388608, 4194303, 4194303, 0);
        random_words(200);
        drain();

        // extremes, high side
        write_all(1024, 0, 65535, 0, 0, 0, 0, 8388607);
        random_words(200);
        drain();

        // typical values, no idling at the end
        write_all(512, 2000, 5000, 16000, -4000000, 400000, 100000, 1000000);
        random_words(100);
        idle_on = 1'b0;
        random_words(100);
        drain();

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
